// ----- sv/hmbs_pkg.sv -----
`timescale 1ns / 1ps
// Package for the height map bilinear sampler: widths, register indexes,
// request kinds and reset values. Depends on nothing.
package hmbs_pkg;

  // Height map store: 16-bit address space, 16-bit signed samples.
  localparam int ADDR_W      = 16;
  localparam int STORE_DEPTH = 1 << ADDR_W;
  localparam int SAMPLE_W    = 16;
  localparam int COORD_W     = 32;
  localparam int GRID_REG_W  = 9;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 32;

  // Smallest usable grid edge; cells need two samples per axis.
  localparam int MIN_GRID = 2;

  // Defaults for the top level parameters.
  localparam int MAX_COLS_DEF  = 256;
  localparam int MAX_ROWS_DEF  = 256;
  localparam int FRAC_BITS_DEF = 16;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ORIGIN_X      = 3'd0,
    CFG_ORIGIN_Y      = 3'd1,
    CFG_INV_SPACING_X = 3'd2,
    CFG_INV_SPACING_Y = 3'd3,
    CFG_GRID_COLS     = 3'd4,
    CFG_GRID_ROWS     = 3'd5,
    CFG_HEIGHT_OFFSET = 3'd6
  } cfg_reg_t;

  // Request kinds carried on tuser.
  typedef enum logic {
    CMD_LOAD  = 1'b0,
    CMD_QUERY = 1'b1
  } cmd_t;

  // Register reset values.
  localparam logic [COORD_W-1:0]    INV_SPACING_RST = 32'h0001_0000;
  localparam logic [GRID_REG_W-1:0] GRID_RST        = 9'd256;

  // Signed 32-bit limits for the height result.
  localparam logic signed [31:0] HEIGHT_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] HEIGHT_MIN = 32'sh8000_0000;

endpackage

// ----- sv/height_map_bilinear_sampler.sv -----
`timescale 1ns / 1ps
// A query request gives its result in m_axis_tdata from the output register of stage 7.
// Throughput: one request (load or query) per cycle unless stalled, set by the 8-stage
// pipeline and the four sample reads per cycle, served by two copies of the height map,
// each with two read ports. Loads give no result. Reset clears the pipeline valids and
// sets the configuration registers to their defaults; the height map is not cleared.
//
// Height map bilinear sampler. Depends on hmbs_pkg.
module height_map_bilinear_sampler
  import hmbs_pkg::*;
#(
  parameter int MAX_COLS  = MAX_COLS_DEF,
  parameter int MAX_ROWS  = MAX_ROWS_DEF,
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  // Configuration write port.
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  // Request stream.
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // tdata from bit 0: sample_index[15:0], sample_value[31:16], point_x[63:32],
  // point_y[95:64].
  input  logic [95:0]           s_axis_tdata,
  input  logic                  s_axis_tlast,   // last_query
  input  logic                  s_axis_tuser,   // command
  // Result stream.
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // tdata from bit 0: out_x[31:0], out_y[63:32], height[95:64].
  output logic [95:0]           m_axis_tdata,
  output logic                  m_axis_tlast    // last_point
);

  // Widths that follow from the parameters.
  localparam int CELL_X_W = (MAX_COLS > 2) ? $clog2(MAX_COLS) : 1;
  localparam int CELL_Y_W = (MAX_ROWS > 2) ? $clog2(MAX_ROWS) : 1;
  localparam int NCOL_W   = $clog2(MAX_COLS + 1);
  localparam int NROW_W   = $clog2(MAX_ROWS + 1);
  localparam int FW       = FRAC_BITS + 1;            // fraction incl. the value 1.0
  localparam int AB_W     = SAMPLE_W + FRAC_BITS + 2; // one-axis blend
  localparam int Z_W      = AB_W + FRAC_BITS + 2;     // two-axis blend
  localparam int SH       = 2 * FRAC_BITS - 8;        // down to Q24.8
  localparam int NSTAGE   = 8;
  localparam logic [FW-1:0] FRAC_ONE = FW'(1) << FRAC_BITS;

  // The stages of the pipeline, by index:
  //   0 input register, offsets from the origin
  //   1 offset times reciprocal spacing
  //   2 cell and fraction per axis, with clamping
  //   3 base address of the cell
  //   4 four samples read from the map (loads write here)
  //   5 blend along x
  //   6 blend along y
  //   7 floor, offset, saturate: the output register

  // ------------------------------------------------------------------
  // Configuration registers
  // ------------------------------------------------------------------
  logic signed [COORD_W-1:0]    origin_x;
  logic signed [COORD_W-1:0]    origin_y;
  logic [COORD_W-1:0]           inv_spacing_x;
  logic [COORD_W-1:0]           inv_spacing_y;
  logic [GRID_REG_W-1:0]        grid_cols;
  logic [GRID_REG_W-1:0]        grid_rows;
  logic signed [COORD_W-1:0]    height_offset;

  always_ff @(posedge clk) begin
    if (rst) begin
      origin_x      <= '0;
      origin_y      <= '0;
      inv_spacing_x <= INV_SPACING_RST;
      inv_spacing_y <= INV_SPACING_RST;
      grid_cols     <= GRID_RST;
      grid_rows     <= GRID_RST;
      height_offset <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_reg_t'(cfg_index))
        CFG_ORIGIN_X:      origin_x      <= cfg_data;
        CFG_ORIGIN_Y:      origin_y      <= cfg_data;
        CFG_INV_SPACING_X: inv_spacing_x <= cfg_data;
        CFG_INV_SPACING_Y: inv_spacing_y <= cfg_data;
        CFG_GRID_COLS:     grid_cols     <= cfg_data[GRID_REG_W-1:0];
        CFG_GRID_ROWS:     grid_rows     <= cfg_data[GRID_REG_W-1:0];
        CFG_HEIGHT_OFFSET: height_offset <= cfg_data;
        default: ;
      endcase
    end
  end

  // Grid size clamped into MIN_GRID..MAX. The user changes configuration only while the
  // block is idle; the block does not enforce this, and the pipeline treats it as static.
  logic [NCOL_W-1:0] cols_c;
  logic [NROW_W-1:0] rows_c;

  always_comb begin
    if (32'(grid_cols) < 32'(MIN_GRID)) begin
      cols_c = NCOL_W'(MIN_GRID);
    end else if (32'(grid_cols) > 32'(MAX_COLS)) begin
      cols_c = NCOL_W'(MAX_COLS);
    end else begin
      cols_c = NCOL_W'(grid_cols);
    end
    if (32'(grid_rows) < 32'(MIN_GRID)) begin
      rows_c = NROW_W'(MIN_GRID);
    end else if (32'(grid_rows) > 32'(MAX_ROWS)) begin
      rows_c = NROW_W'(MAX_ROWS);
    end else begin
      rows_c = NROW_W'(grid_rows);
    end
  end

  // ------------------------------------------------------------------
  // Pipeline flow control: a stage takes new contents when it is empty or
  // when the stage after it moves on. This lets bubbles close up while the
  // output register is held.
  // ------------------------------------------------------------------
  logic [NSTAGE-1:0] v;
  logic [NSTAGE-1:0] rdy;

  always_comb begin
    rdy[NSTAGE-1] = !v[NSTAGE-1] || m_axis_tready;
    for (int k = NSTAGE - 2; k >= 0; k--) begin
      rdy[k] = !v[k] || rdy[k+1];
    end
  end

  assign s_axis_tready = rdy[0];

  // Loads stop at the memory stage; only queries travel past it.
  logic [3:0]     cmd_is_query;
  cmd_t           cmd_p   [4];
  logic [ADDR_W-1:0]   idx_p [4];
  logic [SAMPLE_W-1:0] val_p [4];

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      cmd_is_query[k] = (cmd_p[k] == CMD_QUERY);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      for (int k = 0; k < NSTAGE; k++) begin
        if (rdy[k]) begin
          if (k == 0) begin
            v[k] <= s_axis_tvalid;
          end else if (k == 4) begin
            v[k] <= v[k-1] && cmd_is_query[3];
          end else begin
            v[k] <= v[k-1];
          end
        end
      end
    end
  end

  // Pass-through payload: point coordinates and the batch marker ride along
  // with every stage.
  logic [COORD_W-1:0] x_p    [NSTAGE];
  logic [COORD_W-1:0] y_p    [NSTAGE];
  logic               last_p [NSTAGE];

  always_ff @(posedge clk) begin
    for (int k = 0; k < NSTAGE; k++) begin
      if (rdy[k]) begin
        if (k == 0) begin
          x_p[k]    <= s_axis_tdata[63:32];
          y_p[k]    <= s_axis_tdata[95:64];
          last_p[k] <= s_axis_tlast;
        end else begin
          x_p[k]    <= x_p[k-1];
          y_p[k]    <= y_p[k-1];
          last_p[k] <= last_p[k-1];
        end
      end
    end
  end

  // Load payload lives until the memory stage.
  always_ff @(posedge clk) begin
    for (int k = 0; k < 4; k++) begin
      if (rdy[k]) begin
        if (k == 0) begin
          cmd_p[k] <= cmd_t'(s_axis_tuser);
          idx_p[k] <= s_axis_tdata[15:0];
          val_p[k] <= s_axis_tdata[31:16];
        end else begin
          cmd_p[k] <= cmd_p[k-1];
          idx_p[k] <= idx_p[k-1];
          val_p[k] <= val_p[k-1];
        end
      end
    end
  end

  // ------------------------------------------------------------------
  // Stage 0: offset from the grid origin, 33 bits signed.
  // ------------------------------------------------------------------
  logic signed [COORD_W:0] dx0, dy0;

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      dx0 <= $signed({s_axis_tdata[63], s_axis_tdata[63:32]}) -
             $signed({origin_x[COORD_W-1], origin_x});
      dy0 <= $signed({s_axis_tdata[95], s_axis_tdata[95:64]}) -
             $signed({origin_y[COORD_W-1], origin_y});
    end
  end

  // ------------------------------------------------------------------
  // Stage 1: grid coordinate in Q32.32. A negative offset clamps to cell 0
  // with fraction 0, so only the non-negative magnitude is multiplied.
  // ------------------------------------------------------------------
  logic [2*COORD_W-1:0] prod_x1, prod_y1;
  logic                 neg_x1, neg_y1;

  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      prod_x1 <= (2*COORD_W)'(dx0[COORD_W-1:0]) * (2*COORD_W)'(inv_spacing_x);
      prod_y1 <= (2*COORD_W)'(dy0[COORD_W-1:0]) * (2*COORD_W)'(inv_spacing_y);
      neg_x1  <= dx0[COORD_W];
      neg_y1  <= dy0[COORD_W];
    end
  end

  // ------------------------------------------------------------------
  // Stage 2: cell and fraction. At or beyond the last sample index the cell
  // is pinned to size-2 with fraction 1.0.
  // ------------------------------------------------------------------
  logic [CELL_X_W-1:0] cx_n, cx2;
  logic [CELL_Y_W-1:0] cy_n, cy2;
  logic [FW-1:0]       fx_n, fy_n, fx2, fy2;

  always_comb begin
    if (neg_x1) begin
      cx_n = '0;
      fx_n = '0;
    end else if (prod_x1[2*COORD_W-1:COORD_W] >= 32'(cols_c - NCOL_W'(1))) begin
      cx_n = CELL_X_W'(cols_c - NCOL_W'(MIN_GRID));
      fx_n = FRAC_ONE;
    end else begin
      cx_n = prod_x1[COORD_W +: CELL_X_W];
      fx_n = FW'(prod_x1[COORD_W-1 -: FRAC_BITS]);
    end
    if (neg_y1) begin
      cy_n = '0;
      fy_n = '0;
    end else if (prod_y1[2*COORD_W-1:COORD_W] >= 32'(rows_c - NROW_W'(1))) begin
      cy_n = CELL_Y_W'(rows_c - NROW_W'(MIN_GRID));
      fy_n = FRAC_ONE;
    end else begin
      cy_n = prod_y1[COORD_W +: CELL_Y_W];
      fy_n = FW'(prod_y1[COORD_W-1 -: FRAC_BITS]);
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[2]) begin
      cx2 <= cx_n;
      cy2 <= cy_n;
      fx2 <= fx_n;
      fy2 <= fy_n;
    end
  end

  // ------------------------------------------------------------------
  // Stage 3: linear address of the cell's lower left sample, modulo the
  // store size.
  // ------------------------------------------------------------------
  logic [ADDR_W-1:0] base3;
  logic [FW-1:0]     fx3, fy3;
  logic [31:0]       row_start;

  assign row_start = 32'(cy2) * 32'(cols_c);

  always_ff @(posedge clk) begin
    if (rdy[3]) begin
      base3 <= row_start[ADDR_W-1:0] + ADDR_W'(cx2);
      fx3   <= fx2;
      fy3   <= fy2;
    end
  end

  // ------------------------------------------------------------------
  // Stage 4: the height map. Two identical copies take every load, so that
  // the four neighbours are read in the same cycle: the lower row from one copy,
  // the upper row from the other. Loads write in the same stage where
  // queries read, so program order is kept without forwarding.
  // ------------------------------------------------------------------
  logic [SAMPLE_W-1:0] mem_lo [STORE_DEPTH];
  logic [SAMPLE_W-1:0] mem_hi [STORE_DEPTH];
  logic [ADDR_W-1:0]   a00, a01, a10, a11;
  logic                wr_en;
  logic [SAMPLE_W-1:0] s00, s01, s10, s11;
  logic [FW-1:0]       fx4, fy4;

  assign a00   = base3;
  assign a01   = base3 + ADDR_W'(1);
  assign a10   = base3 + ADDR_W'(cols_c);
  assign a11   = a10 + ADDR_W'(1);
  assign wr_en = rdy[4] && v[3] && !cmd_is_query[3];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_lo[idx_p[3]] <= val_p[3];
    end
    if (rdy[4]) begin
      s00 <= mem_lo[a00];
      s01 <= mem_lo[a01];
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_hi[idx_p[3]] <= val_p[3];
    end
    if (rdy[4]) begin
      s10 <= mem_hi[a10];
      s11 <= mem_hi[a11];
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[4]) begin
      fx4 <= fx3;
      fy4 <= fy3;
    end
  end

  // ------------------------------------------------------------------
  // Stage 5: blend along x for the lower and the upper row.
  // ------------------------------------------------------------------
  logic signed [AB_W-1:0] wx0, wx1;
  logic signed [AB_W-1:0] a5, b5;
  logic [FW-1:0]          fy5;

  assign wx1 = AB_W'(fx4);
  assign wx0 = AB_W'(FRAC_ONE - fx4);

  always_ff @(posedge clk) begin
    if (rdy[5]) begin
      a5  <= AB_W'($signed(s00)) * wx0 + AB_W'($signed(s01)) * wx1;
      b5  <= AB_W'($signed(s10)) * wx0 + AB_W'($signed(s11)) * wx1;
      fy5 <= fy4;
    end
  end

  // ------------------------------------------------------------------
  // Stage 6: blend along y, exact in Q(2*FRAC_BITS).
  // ------------------------------------------------------------------
  logic signed [Z_W-1:0] wy0, wy1;
  logic signed [Z_W-1:0] z6;

  assign wy1 = Z_W'(fy5);
  assign wy0 = Z_W'(FRAC_ONE - fy5);

  always_ff @(posedge clk) begin
    if (rdy[6]) begin
      z6 <= Z_W'(a5) * wy0 + Z_W'(b5) * wy1;
    end
  end

  // ------------------------------------------------------------------
  // Stage 7: the arithmetic shift floors toward minus infinity; the offset
  // is added and the sum saturates to 32 bits.
  // ------------------------------------------------------------------
  localparam logic signed [Z_W-1:0] SAT_HI = Z_W'(HEIGHT_MAX);
  localparam logic signed [Z_W-1:0] SAT_LO = Z_W'(HEIGHT_MIN);

  logic signed [Z_W-1:0]     h_sum;
  logic signed [COORD_W-1:0] h_sat, h7;

  always_comb begin
    h_sum = (z6 >>> SH) + Z_W'(height_offset);
    if (h_sum > SAT_HI) begin
      h_sat = HEIGHT_MAX;
    end else if (h_sum < SAT_LO) begin
      h_sat = HEIGHT_MIN;
    end else begin
      h_sat = h_sum[COORD_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[7]) begin
      h7 <= h_sat;
    end
  end

  assign m_axis_tvalid = v[NSTAGE-1];
  assign m_axis_tdata  = {h7, y_p[NSTAGE-1], x_p[NSTAGE-1]};
  assign m_axis_tlast  = last_p[NSTAGE-1];

  // ------------------------------------------------------------------
  // Assertions
  // ------------------------------------------------------------------

  // With the output register empty nothing can hold the pipeline back.
  a_ready_when_out_empty: assert property (@(posedge clk) disable iff (rst)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("request refused while the output register is empty");

  // A located x cell always leaves room for its right neighbour.
  a_cell_x_range: assert property (@(posedge clk) disable iff (rst)
    v[2] |-> (32'(cx2) <= 32'(cols_c) - 32'(MIN_GRID)))
    else $error("x cell beyond the last usable column");

  // A located y cell always leaves room for the row above.
  a_cell_y_range: assert property (@(posedge clk) disable iff (rst)
    v[2] |-> (32'(cy2) <= 32'(rows_c) - 32'(MIN_GRID)))
    else $error("y cell beyond the last usable row");

  // A full fraction only appears together with the clamped last cell.
  a_full_frac_clamped: assert property (@(posedge clk) disable iff (rst)
    (v[2] && fx2 == FRAC_ONE) |-> (32'(cx2) == 32'(cols_c) - 32'(MIN_GRID)))
    else $error("fraction of one outside the last x cell");

  // A load never leaves the memory stage as a result.
  a_load_no_result: assert property (@(posedge clk) disable iff (rst)
    (rdy[4] && v[3] && !cmd_is_query[3]) |=> !v[4])
    else $error("load request passed the memory stage");

endmodule

// ----- bench/testbench.sv -----
`timescale 1ns / 1ps
// Self-checking bench for height_map_bilinear_sampler: loads height samples, fires query
// points through the request stream and checks each returned point against its own model.
// Depends on hmbs_pkg and the sampler RTL.
module testbench;
  import hmbs_pkg::*;

  localparam int RUN_LIMIT = 300000;  // cycles; far above the slowest correct run
  localparam int DRAIN     = 16;      // pipeline is 8 deep, trailing loads give no result
  localparam int FRAC_ONE  = 1 << FRAC_BITS_DEF;
  localparam int BLEND_SH  = 2 * FRAC_BITS_DEF - 8;  // Q(2*FRAC) blend down to Q24.8

  // One request on the input stream: a sample load or a query point.
  typedef struct packed {
    cmd_t               cmd;
    logic [15:0]        index;
    logic signed [15:0] value;
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic               last;
  } request_t;

  // One returned point.
  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] height;
    logic               last;
  } point_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                  cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = CFG_ORIGIN_X;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  // From bit 0: sample_index, sample_value, point_x, point_y.
  logic [95:0] s_axis_tdata  = '0;
  logic        s_axis_tlast  = 1'b0;  // last_query
  logic        s_axis_tuser  = 1'b0;  // command
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  // From bit 0: out_x, out_y, height.
  logic [95:0] m_axis_tdata;
  logic        m_axis_tlast;          // last_point

  height_map_bilinear_sampler dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #4 clk = ~clk;

  // Our copy of the register file, at its reset values.
  logic signed [31:0] org_x      = '0;
  logic signed [31:0] org_y      = '0;
  logic [31:0]        inv_x      = INV_SPACING_RST;
  logic [31:0]        inv_y      = INV_SPACING_RST;
  logic [8:0]         cols_reg   = GRID_RST;
  logic [8:0]         rows_reg   = GRID_RST;
  logic signed [31:0] offset_reg = '0;

  // map_copy follows the samples as the block accepts them. loaded marks every entry
  // that some queued load will write, so no query is ever built that reads an entry
  // nobody has written (the RTL does not clear its store on reset).
  logic signed [15:0] map_copy [0:STORE_DEPTH-1];
  bit                 loaded   [0:STORE_DEPTH-1];

  request_t requests[$];        // requests waiting to go out on the input stream
  point_t   sampled_points[$];  // points the block owes us, oldest first

  request_t cur_req;
  point_t   want, got;
  int       send_gap    = 0;
  int       stall_left  = 0;
  int       idle_odds   = 8;    // 1 in idle_odds chance of a burst; 0 turns bursts off
  int       errors      = 0;
  int       cycle_count = 0;

  // Clamp a grid edge into 2..maxn as the block does.
  function automatic int grid_span(logic [8:0] n, int maxn);
    if (n < MIN_GRID) return MIN_GRID;
    if (n > maxn) return maxn;
    return n;
  endfunction

  // Map one axis offset to a cell and a fraction. The grid coordinate is the exact
  // Q32.32 product of the offset and the reciprocal spacing; anything below the origin
  // sticks to cell 0, anything at or past the last index to the last cell at fraction 1.
  function automatic void locate_axis(input longint diff, input logic [31:0] inv,
                                      input int n, output int cell_idx, output int frac);
    logic [63:0] prod;
    if (diff < 0) begin
      cell_idx = 0;
      frac     = 0;
    end else begin
      prod = 64'(diff) * {32'd0, inv};
      if (prod[63:32] >= n - 1) begin
        cell_idx = n - 2;
        frac     = FRAC_ONE;
      end else begin
        cell_idx = int'(prod[63:32]);
        frac     = int'((prod >> (32 - FRAC_BITS_DEF)) & 64'(FRAC_ONE - 1));
      end
    end
  endfunction

  // The four store addresses a query reads, plus its fractions. Used both when building
  // queries and when predicting their heights.
  function automatic void locate_corners(input logic signed [31:0] px,
                                         input logic signed [31:0] py,
                                         output logic [3:0][15:0] addr,
                                         output int fx, output int fy);
    int          cols, rows, cx, cy;
    logic [31:0] base;
    cols = grid_span(cols_reg, MAX_COLS_DEF);
    rows = grid_span(rows_reg, MAX_ROWS_DEF);
    locate_axis(longint'(px) - longint'(org_x), inv_x, cols, cx, fx);
    locate_axis(longint'(py) - longint'(org_y), inv_y, rows, cy, fy);
    base    = cy * cols + cx;
    addr[0] = 16'(base);
    addr[1] = 16'(base + 1);
    addr[2] = 16'(base + cols);
    addr[3] = 16'(base + cols + 1);
  endfunction

  // Height of a query point: exact bilinear blend, floored to Q24.8, plus the offset,
  // saturated to 32 bits. Coordinates and the batch mark pass through.
  function automatic point_t bilinear_height(request_t r);
    logic [3:0][15:0] addr;
    int               fx, fy;
    longint           s00, s01, s10, s11, wx0, wx1, wy0, wy1, a, b, z, h;
    point_t           p;
    locate_corners(r.px, r.py, addr, fx, fy);
    s00 = map_copy[addr[0]];
    s01 = map_copy[addr[1]];
    s10 = map_copy[addr[2]];
    s11 = map_copy[addr[3]];
    wx1 = fx;
    wx0 = FRAC_ONE - fx;
    wy1 = fy;
    wy0 = FRAC_ONE - fy;
    a = s00 * wx0 + s01 * wx1;
    b = s10 * wx0 + s11 * wx1;
    z = a * wy0 + b * wy1;
    h = (z >>> BLEND_SH) + longint'(offset_reg);
    if (h > longint'(HEIGHT_MAX)) h = HEIGHT_MAX;
    if (h < longint'(HEIGHT_MIN)) h = HEIGHT_MIN;
    p.x      = r.px;
    p.y      = r.py;
    p.height = h[31:0];
    p.last   = r.last;
    return p;
  endfunction

  // Sample values lean on the two extremes now and then.
  function automatic logic [15:0] pick_sample();
    case ($urandom_range(0, 7))
      0:       return 16'h8000;
      1:       return 16'h7FFF;
      default: return 16'($urandom);
    endcase
  endfunction

  // A coordinate for one axis. Most land on or around the grid so that interpolation,
  // the clamp below the origin and the clamp at the last index all get exercised.
  function automatic logic [31:0] aim_coord(logic signed [31:0] org, logic [31:0] inv,
                                            int n);
    longint t, dx;
    case ($urandom_range(0, 11))
      0:       return $urandom;
      1:       return org;
      2:       t = -longint'($urandom_range(1, FRAC_ONE));
      3:       t = longint'(n - 1) << FRAC_BITS_DEF;
      4:       t = longint'($urandom_range(0, n + 1)) << FRAC_BITS_DEF;
      default: t = $urandom_range(0, (n + 1) << FRAC_BITS_DEF);
    endcase
    // Round the offset up so the product reaches the aimed grid position.
    if (t < 0 || inv == 0) dx = t;
    else dx = ((t << 16) + inv - 1) / inv;
    if (dx > longint'(32'hFFFF_FFFF)) dx = longint'(32'hFFFF_FFFF);
    return 32'(longint'(org) + dx);
  endfunction

  task automatic add_load(logic [15:0] idx, logic [15:0] val);
    request_t r;
    r.cmd   = CMD_LOAD;
    r.index = idx;
    r.value = val;
    r.px    = $urandom;
    r.py    = $urandom;
    r.last  = 1'($urandom_range(0, 1));
    loaded[idx] = 1'b1;
    requests.push_back(r);
  endtask

  // Queue a query, preceded by loads for any corner sample that is still unwritten.
  task automatic add_query(logic signed [31:0] px, logic signed [31:0] py, logic last);
    request_t         r;
    logic [3:0][15:0] addr;
    int               fx, fy;
    locate_corners(px, py, addr, fx, fy);
    for (int i = 0; i < 4; i++) begin
      if (!loaded[addr[i]]) add_load(addr[i], pick_sample());
    end
    r.cmd   = CMD_QUERY;
    r.index = 16'($urandom);
    r.value = 16'($urandom);
    r.px    = px;
    r.py    = py;
    r.last  = last;
    requests.push_back(r);
  endtask

  // Random query points in batches of random length, with a stray load here and there
  // to some arbitrary address, inside the grid or far outside it.
  task automatic add_random_queries(int count);
    int cols, rows;
    cols = grid_span(cols_reg, MAX_COLS_DEF);
    rows = grid_span(rows_reg, MAX_ROWS_DEF);
    repeat (count) begin
      if ($urandom_range(0, 9) == 0) add_load(16'($urandom), pick_sample());
      add_query(aim_coord(org_x, inv_x, cols), aim_coord(org_y, inv_y, rows),
                $urandom_range(0, 3) == 0);
    end
  endtask

  // Wait, at falling edges so that the clocked blocks have settled, until the input
  // stream is empty and every owed point has come back.
  task automatic wait_idle();
    @(negedge clk);
    while (requests.size() != 0 || s_axis_tvalid || sampled_points.size() != 0)
      @(negedge clk);
  endtask

  // One register write, mirrored into our copy.
  task automatic cfg_write(cfg_reg_t idx, logic [31:0] val);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    case (idx)
      CFG_ORIGIN_X:      org_x      = val;
      CFG_ORIGIN_Y:      org_y      = val;
      CFG_INV_SPACING_X: inv_x      = val;
      CFG_INV_SPACING_Y: inv_y      = val;
      CFG_GRID_COLS:     cols_reg   = val[8:0];
      CFG_GRID_ROWS:     rows_reg   = val[8:0];
      CFG_HEIGHT_OFFSET: offset_reg = val;
      default: ;
    endcase
  endtask

  // Reprogram every register. The sender holds off until the block has drained,
  // including any loads still moving down the pipeline behind the last result.
  task automatic set_grid(logic [31:0] ox, logic [31:0] oy, logic [31:0] ix,
                          logic [31:0] iy, logic [31:0] c, logic [31:0] r,
                          logic [31:0] off);
    wait_idle();
    repeat (DRAIN) @(posedge clk);
    cfg_write(CFG_ORIGIN_X, ox);
    cfg_write(CFG_ORIGIN_Y, oy);
    cfg_write(CFG_INV_SPACING_X, ix);
    cfg_write(CFG_INV_SPACING_Y, iy);
    cfg_write(CFG_GRID_COLS, c);
    cfg_write(CFG_GRID_ROWS, r);
    cfg_write(CFG_HEIGHT_OFFSET, off);
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    @(negedge clk);
    idle_odds = $urandom_range(3, 20);
  endtask

  // A register setting drawn at random, mostly small grids near the origin.
  task automatic set_random_grid();
    logic [31:0] ox, oy, ix, iy, c, r, off;
    ox = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 1 << 20) - (1 << 19);
    oy = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 1 << 20) - (1 << 19);
    case ($urandom_range(0, 3))
      0, 1:    ix = INV_SPACING_RST;
      2:       ix = $urandom;
      default: ix = $urandom_range(32'h4000, 32'h40000);
    endcase
    case ($urandom_range(0, 3))
      0, 1:    iy = INV_SPACING_RST;
      2:       iy = $urandom;
      default: iy = $urandom_range(32'h4000, 32'h40000);
    endcase
    c   = ($urandom_range(0, 5) == 0) ? $urandom : $urandom_range(2, 12);
    r   = ($urandom_range(0, 5) == 0) ? $urandom : $urandom_range(2, 12);
    off = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 1 << 16) - (1 << 15);
    set_grid(ox, oy, ix, iy, c, r, off);
  endtask

  // Compare one field of a returned point.
  task automatic compare_field(string name, logic [31:0] exp_val, logic [31:0] act_val);
    if (exp_val !== act_val) begin
      errors++;
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_val, act_val);
    end
  endtask

  // Stimulus. Each phase programs the registers on an idle block and then queues the
  // whole phase at once; the driver below feeds it out.
  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Small 4 x 3 grid at unit spacing: the extremes of samples, index and coordinates,
    // points on the origin, below it, on and past the last index, and plain fractions.
    set_grid(0, 0, INV_SPACING_RST, INV_SPACING_RST, 4, 3, 0);
    for (int i = 0; i < 12; i++)
      add_load(i, (i == 0) ? 16'h8000 : (i == 1) ? 16'h7FFF : pick_sample());
    add_load(16'hFFFF, 16'h7FFF);
    add_query(32'h0, 32'h0, 1'b0);
    add_query(32'h3_0000, 32'h2_0000, 1'b0);
    add_query(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
    add_query(32'h7FFF_FFFF, 32'h8000_0000, 1'b0);
    add_query(32'h8000_0000, 32'h7FFF_FFFF, 1'b1);
    add_query(32'h1_8000, 32'h0_4000, 1'b0);
    add_query(32'h2_FFFF, 32'h1_FFFF, 1'b0);
    add_query(32'h1_0000, 32'h1_0000, 1'b1);
    add_random_queries(60);

    // Smallest grid, half and double spacing, an offset that drives heights into
    // positive saturation.
    set_grid(-32'sh3_0000, 32'h1_2345, 32'h2_0000, 32'h8000, 2, 2, 32'h7FFF_FF00);
    add_random_queries(60);

    // Grid edges below the minimum, a zero reciprocal on x, the largest reciprocal on
    // y, origins at the extremes and an offset that saturates negative heights.
    set_grid(32'h7FFF_FFFF, 32'h8000_0000, 0, 32'hFFFF_FFFF, 0, 1, 32'h8000_0000);
    add_random_queries(40);

    // Grid edges above the maximum clamp to the full 256 x 256 map.
    set_grid($urandom_range(0, 1 << 20), 0, INV_SPACING_RST, INV_SPACING_RST, 257, 511,
             $urandom);
    add_random_queries(40);

    repeat (5) begin
      set_random_grid();
      add_random_queries(60);
    end

    // Last part: both sides run flat out with no idling.
    set_random_grid();
    idle_odds = 0;
    add_random_queries(150);

    wait_idle();
    repeat (DRAIN) @(posedge clk);
    if (errors == 0 && sampled_points.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // Driver: presents the next request whenever the slot is free, inserting random idle
  // bursts between requests. An accepted query's result is predicted on the spot, and an
  // accepted load updates our copy of the map.
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        if (cur_req.cmd == CMD_LOAD) map_copy[cur_req.index] = cur_req.value;
        else sampled_points.push_back(bilinear_height(cur_req));
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (send_gap > 0) begin
          send_gap--;
          s_axis_tvalid <= 1'b0;
        end else if (requests.size() > 0) begin
          cur_req = requests.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= {cur_req.py, cur_req.px, cur_req.value, cur_req.index};
          s_axis_tuser  <= cur_req.cmd;
          s_axis_tlast  <= cur_req.last;
          if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1)
            send_gap = $urandom_range(1, 9);
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: stalls the result stream in random bursts and checks every accepted point
  // against the oldest prediction.
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = {m_axis_tdata[31:0], m_axis_tdata[63:32], m_axis_tdata[95:64], m_axis_tlast};
        if (sampled_points.size() == 0) begin
          errors++;
          $display("%0t: point with no query waiting, expected none, actual %h", $time, got);
        end else begin
          want = sampled_points.pop_front();
          compare_field("out_x", want.x, got.x);
          compare_field("out_y", want.y, got.y);
          compare_field("height", want.height, got.height);
          compare_field("last_point", want.last, got.last);
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
        if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1)
          stall_left = $urandom_range(1, 9);
      end
    end
  end

  // Watchdog for a hung handshake or a lost result.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == RUN_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

endmodule
